// ===== rtl/cfbt_pkg.sv =====
// Shared types and constants of the cuckoo filter bucket table.
// No dependencies; imported by the channel interfaces and the top level.
package cfbt_pkg;

   localparam int BUCKET_COUNT = 1024;
   localparam int BUCKET_AW    = $clog2(BUCKET_COUNT);
   localparam int FP_BITS      = 12;
   localparam int SLOTS        = 4;
   localparam int SLOT_AW      = $clog2(SLOTS);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_SWAP   = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef logic [FP_BITS-1:0]             fp_type;
   typedef logic [BUCKET_AW-1:0]           bidx_type;
   typedef logic [SLOT_AW-1:0]             slot_type;
   typedef logic [SLOTS-1:0][FP_BITS-1:0]  bucket_type;

endpackage

// ===== rtl/cfbt_req_if.sv =====
// Request channel of the bucket table: valid/ready plus operation fields.
// Depends on cfbt_pkg.
interface cfbt_req_if import cfbt_pkg::*; ();
   logic     valid;
   logic     ready;
   op_type   operation;
   fp_type   fingerprint;
   bidx_type primary_index;
   bidx_type alternate_index;
   slot_type victim_slot;

   modport source (output valid, operation, fingerprint, primary_index,
                   alternate_index, victim_slot, input ready);
   modport sink   (input valid, operation, fingerprint, primary_index,
                   alternate_index, victim_slot, output ready);
endinterface

// ===== rtl/cfbt_rsp_if.sv =====
// Response channel of the bucket table: valid/ready plus result fields.
// Depends on cfbt_pkg.
interface cfbt_rsp_if import cfbt_pkg::*; ();
   logic   valid;
   logic   ready;
   logic   found;
   logic   bucket_full;
   fp_type evicted_fingerprint;

   modport source (output valid, found, bucket_full, evicted_fingerprint,
                   input ready);
   modport sink   (input valid, found, bucket_full, evicted_fingerprint,
                   output ready);
endinterface

// ===== rtl/cuckoo_filter_bucket_table.sv =====
// Cuckoo filter bucket table: 1024 buckets of four 12-bit fingerprint slots.
// A request is registered in stage 1 with its bucket words, then in the output register.
// Throughput: one request per cycle unless responses stall; bucket RAM reads two words and writes one.
// Reset: synchronous; a clearing pass then zeroes the RAM, one bucket per
// cycle, while requests are held off.
// Depends on cfbt_pkg, cfbt_req_if, cfbt_rsp_if.
module cuckoo_filter_bucket_table import cfbt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   cfbt_req_if.sink       req_ch,
   cfbt_rsp_if.source     rsp_ch
);

   // Bucket RAM, one word per bucket, read before write.
   bucket_type bucket_mem [BUCKET_COUNT];

   // Clearing pass after reset
   logic     clearing_ff, clearing_in;
   bidx_type clr_cnt_ff,  clr_cnt_in;

   // Stage 1: request whose bucket words are being read
   logic     s1_valid_ff, s1_valid_in;
   op_type   s1_op_ff;
   fp_type   s1_fp_ff;
   bidx_type s1_pidx_ff;
   bidx_type s1_aidx_ff;
   slot_type s1_vslot_ff;
   bucket_type rd_p_ff;
   bucket_type rd_a_ff;

   // Last write, forwarded to a read that raced it
   logic       fwd_valid_ff, fwd_valid_in;
   bidx_type   fwd_idx_ff;
   bucket_type fwd_data_ff;

   // Output register
   logic   out_valid_ff, out_valid_in;
   logic   out_found_ff;
   logic   out_full_ff;
   fp_type out_evict_ff;

   logic       accept;
   logic       s1_adv;
   bucket_type prim;
   bucket_type alt;
   logic       hit_p, hit_a;
   logic       full;
   logic       rm_hit;
   slot_type   rm_slot;
   slot_type   ins_slot;
   bucket_type new_bucket;
   logic       op_wr;
   logic       found;
   fp_type     evict;
   logic       wr_en;
   bidx_type   wr_idx;
   bucket_type wr_data;

   // Stage 1 moves on when the output register is free or being drained.
   assign s1_adv       = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign accept       = req_ch.valid && req_ch.ready;

   // Forwarding: the previous write landed in the same edge as our read.
   always_comb begin
      prim = rd_p_ff;
      alt  = rd_a_ff;
      if (fwd_valid_ff && fwd_idx_ff == s1_pidx_ff) begin
         prim = fwd_data_ff;
      end
      if (fwd_valid_ff && fwd_idx_ff == s1_aidx_ff) begin
         alt = fwd_data_ff;
      end
   end

   // Slot compares, all four in parallel
   always_comb begin
      hit_p    = 1'b0;
      hit_a    = 1'b0;
      full     = 1'b1;
      rm_hit   = 1'b0;
      rm_slot  = '0;
      ins_slot = slot_type'(SLOTS - 1);
      for (int s = 0; s < SLOTS; s++) begin
         if (prim[s] == s1_fp_ff) begin
            hit_p = 1'b1;
         end
         if (alt[s] == s1_fp_ff) begin
            hit_a = 1'b1;
         end
         if (prim[s] == '0) begin
            full = 1'b0;
         end
      end
      // first matching slot for remove
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (prim[s] == s1_fp_ff) begin
            rm_hit  = 1'b1;
            rm_slot = slot_type'(s);
         end
      end
      // first empty slot among the first three, else the last one
      for (int s = SLOTS - 2; s >= 0; s--) begin
         if (prim[s] == '0) begin
            ins_slot = slot_type'(s);
         end
      end
      // zero is the empty marker, never a match
      if (s1_fp_ff == '0) begin
         hit_p  = 1'b0;
         hit_a  = 1'b0;
         rm_hit = 1'b0;
      end
   end

   // Per-operation result and bucket update
   always_comb begin
      new_bucket = prim;
      op_wr      = 1'b0;
      found      = 1'b0;
      evict      = '0;
      case (s1_op_ff)
         OP_LOOKUP: begin
            found = hit_p || hit_a;
         end
         OP_INSERT: begin
            new_bucket[ins_slot] = s1_fp_ff;
            op_wr                = 1'b1;
         end
         OP_SWAP: begin
            evict                   = prim[s1_vslot_ff];
            new_bucket[s1_vslot_ff] = s1_fp_ff;
            op_wr                   = 1'b1;
         end
         OP_REMOVE: begin
            found               = rm_hit;
            new_bucket[rm_slot] = '0;
            op_wr               = rm_hit;
         end
         default: begin
            found = 1'b0;
         end
      endcase
   end

   // Single write port shared by the clearing pass and the update path.
   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_idx  = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_valid_ff && s1_adv && op_wr;
         wr_idx  = s1_pidx_ff;
         wr_data = new_bucket;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bucket_mem[wr_idx] <= wr_data;
      end
      if (accept) begin
         rd_p_ff <= bucket_mem[req_ch.primary_index];
         rd_a_ff <= bucket_mem[req_ch.alternate_index];
      end
   end

   // Next-state for control registers
   always_comb begin
      clearing_in  = clearing_ff;
      clr_cnt_in   = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == bidx_type'(BUCKET_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end
      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      out_valid_in = (s1_valid_ff && s1_adv) ? 1'b1
                   : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      fwd_valid_in = fwd_valid_ff || wr_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_ch.operation;
         s1_fp_ff    <= req_ch.fingerprint;
         s1_pidx_ff  <= req_ch.primary_index;
         s1_aidx_ff  <= req_ch.alternate_index;
         s1_vslot_ff <= req_ch.victim_slot;
      end
      if (wr_en) begin
         fwd_idx_ff  <= wr_idx;
         fwd_data_ff <= wr_data;
      end
      if (s1_valid_ff && s1_adv) begin
         out_found_ff <= found;
         out_full_ff  <= full;
         out_evict_ff <= evict;
      end
   end

   assign rsp_ch.valid               = out_valid_ff;
   assign rsp_ch.found               = out_found_ff;
   assign rsp_ch.bucket_full         = out_full_ff;
   assign rsp_ch.evicted_fingerprint = out_evict_ff;

endmodule

// ===== dv/tb_cuckoo_filter_bucket_table.sv =====
// Testbench for the cuckoo filter bucket table: directed table, then random requests.
// Results are checked against a local model of the bucket store.
// Depends on cfbt_pkg, cfbt_req_if, cfbt_rsp_if and cuckoo_filter_bucket_table.
`timescale 1ns / 100ps

module tb_cuckoo_filter_bucket_table import cfbt_pkg::*; ();

   localparam int RANDOM_PER_PHASE = 242;     // three phases, ~750 requests in all
   localparam int DRAIN_CYCLES     = 10;      // idle margin after the last response
   localparam int CYCLE_LIMIT      = 200_000; // clearing pass + worst stalls, many times over
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      op_type   operation;
      fp_type   fingerprint;
      bidx_type primary_index;
      bidx_type alternate_index;
      slot_type victim_slot;
   } bucket_request_type;

   typedef struct packed {
      logic   found;
      logic   bucket_full;
      fp_type evicted_fingerprint;
   } bucket_result_type;

   // One line of the directed table. When typed is set, outcome is the
   // hand-written answer and replaces the model's prediction.
   typedef struct packed {
      bucket_request_type stimulus;
      bit                 typed;
      bucket_result_type  outcome;
   } directed_row_type;

   logic clock;
   logic reset;

   cfbt_req_if req_ch ();
   cfbt_rsp_if rsp_ch ();

   cuckoo_filter_bucket_table u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Local image of the bucket RAM and the results still owed by the block.
   bucket_type         bucket_image [BUCKET_COUNT];
   bucket_result_type  pending_results [$];
   directed_row_type   directed_plan [$];

   int sender_idle_pct;
   int receiver_idle_pct;
   int error_count;
   int cycle_count;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit. Covers the clearing pass after reset as well.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout: %0d results still outstanding", pending_results.size());
         $display("cuckoo_filter_bucket_table test failed");
         $finish;
      end
   end

   // Receiver: back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Zero marks an empty slot and never matches.
   function automatic bit holds_fingerprint(bucket_type bucket, fp_type fp);
      if (fp == '0)
         return 1'b0;
      for (int s = 0; s < SLOTS; s++)
         if (bucket[s] == fp)
            return 1'b1;
      return 1'b0;
   endfunction

   // Applies one request to the bucket image and returns its result.
   function automatic bucket_result_type predict_operation(bucket_request_type item);
      bucket_result_type outcome;
      bucket_type        primary;
      int                slot;
      primary = bucket_image[item.primary_index];
      outcome = '0;
      // Fullness is taken before the request touches the bucket.
      outcome.bucket_full = 1'b1;
      for (int s = 0; s < SLOTS; s++)
         if (primary[s] == '0)
            outcome.bucket_full = 1'b0;
      case (item.operation)
         OP_LOOKUP: begin
            outcome.found = holds_fingerprint(primary, item.fingerprint) ||
                            holds_fingerprint(bucket_image[item.alternate_index],
                                              item.fingerprint);
         end
         OP_INSERT: begin
            // First empty slot, else the last slot gets overwritten.
            slot = 0;
            while (slot < SLOTS - 1 && primary[slot] != '0)
               slot++;
            primary[slot] = item.fingerprint;
         end
         OP_SWAP: begin
            outcome.evicted_fingerprint = primary[item.victim_slot];
            primary[item.victim_slot]   = item.fingerprint;
         end
         OP_REMOVE: begin
            // Only the first matching slot is cleared.
            if (item.fingerprint != '0) begin
               for (slot = 0; slot < SLOTS; slot++) begin
                  if (!outcome.found && primary[slot] == item.fingerprint) begin
                     primary[slot] = '0;
                     outcome.found = 1'b1;
                  end
               end
            end
         end
         default: begin
            outcome.found = 1'b0;
         end
      endcase
      bucket_image[item.primary_index] = primary;
      return outcome;
   endfunction

   function automatic void plan_row(op_type op, int unsigned fp, int unsigned pb,
                                    int unsigned ab, int unsigned vs, bit typed,
                                    bit found, bit full, int unsigned evicted);
      directed_row_type row;
      row.stimulus.operation       = op;
      row.stimulus.fingerprint     = fp_type'(fp);
      row.stimulus.primary_index   = bidx_type'(pb);
      row.stimulus.alternate_index = bidx_type'(ab);
      row.stimulus.victim_slot     = slot_type'(vs);
      row.typed                    = typed;
      row.outcome.found               = found;
      row.outcome.bucket_full         = full;
      row.outcome.evicted_fingerprint = fp_type'(evicted);
      directed_plan.push_back(row);
   endfunction

   // Directed table. Buckets 0x000 and 0x3FF are filled, drained and reused;
   // typed answers only where they are obvious from the bucket contents.
   function automatic void load_directed_plan();
      //       operation  fp      prim    alt     vs typ fnd ful evicted
      // Empty store right after reset.
      plan_row(OP_LOOKUP, 'hFFF, 'h000, 'h3FF, 0, 1, 0, 0, 'h000);
      plan_row(OP_REMOVE, 'h123, 'h3FF, 'h000, 0, 1, 0, 0, 'h000);
      plan_row(OP_SWAP,   'hABC, 'h3FF, 'h000, 3, 1, 0, 0, 'h000);
      // Fill bucket 0, then insert into the full bucket (overwrites last slot).
      plan_row(OP_INSERT, 'hFFF, 'h000, 'h000, 0, 1, 0, 0, 'h000);
      plan_row(OP_INSERT, 'h001, 'h000, 'h3FF, 1, 0, 0, 0, 'h000);
      plan_row(OP_INSERT, 'h800, 'h000, 'h000, 2, 0, 0, 0, 'h000);
      plan_row(OP_INSERT, 'h7FF, 'h000, 'h000, 3, 0, 0, 0, 'h000);
      plan_row(OP_LOOKUP, 'h800, 'h005, 'h000, 0, 0, 0, 0, 'h000);
      plan_row(OP_INSERT, 'h555, 'h000, 'h000, 0, 1, 0, 1, 'h000);
      plan_row(OP_LOOKUP, 'h7FF, 'h000, 'h3FF, 0, 0, 0, 0, 'h000);
      // Swap returns the old slot content; swapping in zero empties a slot.
      plan_row(OP_SWAP,   'hAAA, 'h000, 'h000, 0, 1, 0, 1, 'hFFF);
      plan_row(OP_SWAP,   'h000, 'h000, 'h000, 1, 1, 0, 1, 'h001);
      // Zero fingerprint never matches; inserting zero leaves the slot empty.
      plan_row(OP_LOOKUP, 'h000, 'h000, 'h000, 0, 0, 0, 0, 'h000);
      plan_row(OP_INSERT, 'h000, 'h000, 'h000, 0, 0, 0, 0, 'h000);
      plan_row(OP_REMOVE, 'h000, 'h000, 'h000, 0, 0, 0, 0, 'h000);
      plan_row(OP_REMOVE, 'h800, 'h000, 'h000, 0, 1, 1, 0, 'h000);
      plan_row(OP_REMOVE, 'h800, 'h000, 'h000, 0, 0, 0, 0, 'h000);
      // Duplicates in bucket 0x3FF; inserting zero into a full bucket clears slot four.
      plan_row(OP_INSERT, 'h3C3, 'h3FF, 'h000, 0, 0, 0, 0, 'h000);
      plan_row(OP_INSERT, 'h3C3, 'h3FF, 'h000, 0, 0, 0, 0, 'h000);
      plan_row(OP_INSERT, 'h111, 'h3FF, 'h000, 0, 0, 0, 0, 'h000);
      plan_row(OP_INSERT, 'h000, 'h3FF, 'h000, 0, 1, 0, 1, 'h000);
      plan_row(OP_LOOKUP, 'hABC, 'h000, 'h3FF, 0, 0, 0, 0, 'h000);
      plan_row(OP_REMOVE, 'h3C3, 'h3FF, 'h000, 0, 1, 1, 0, 'h000);
      plan_row(OP_LOOKUP, 'h3C3, 'h200, 'h3FF, 0, 0, 0, 0, 'h000);
      plan_row(OP_SWAP,   'h5A5, 'h3FF, 'h000, 2, 1, 0, 0, 'h111);
   endfunction

   // Random request. Most traffic lands on a handful of buckets with a small
   // set of fingerprints, so buckets fill up, overflow and hit on lookup and
   // remove; the rest is spread over the full field ranges.
   function automatic bucket_request_type random_request();
      bucket_request_type item;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 32)
         item.operation = OP_INSERT;
      else if (pick < 57)
         item.operation = OP_LOOKUP;
      else if (pick < 85)
         item.operation = OP_REMOVE;
      else
         item.operation = OP_SWAP;

      pick = $urandom_range(99);
      if (pick < 5)
         item.fingerprint = '0;
      else if (pick < 15)
         item.fingerprint = fp_type'($urandom);
      else
         item.fingerprint = fp_type'($urandom_range(1, 12) * 'h155);

      if ($urandom_range(99) < 80)
         item.primary_index = bidx_type'($urandom_range(0, 5) * 'h0CC);
      else
         item.primary_index = bidx_type'($urandom);
      if ($urandom_range(99) < 70)
         item.alternate_index = bidx_type'($urandom_range(0, 5) * 'h0CC);
      else
         item.alternate_index = bidx_type'($urandom);

      item.victim_slot = slot_type'($urandom_range(SLOTS - 1));
      return item;
   endfunction

   // Drives one request, waits for the handshake and records what the
   // block owes for it.
   task automatic issue_request(input bucket_request_type item, input bit typed,
                                input bucket_result_type typed_result);
      bucket_result_type outcome;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.operation       <= item.operation;
      req_ch.fingerprint     <= item.fingerprint;
      req_ch.primary_index   <= item.primary_index;
      req_ch.alternate_index <= item.alternate_index;
      req_ch.victim_slot     <= item.victim_slot;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      // Accepted at this edge: update the image in request order.
      outcome = predict_operation(item);
      if (typed)
         outcome = typed_result;
      pending_results.push_back(outcome);
   endtask

   // Response checker: every accepted response against the oldest prediction.
   always @(posedge clock) begin : check_responses
      bucket_result_type wanted;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf(
               "response with no request outstanding: found=%0b full=%0b evicted=%03h",
               rsp_ch.found, rsp_ch.bucket_full, rsp_ch.evicted_fingerprint));
         end else begin
            wanted = pending_results.pop_front();
            if (rsp_ch.found !== wanted.found)
               report_mismatch($sformatf("found expected %0b got %0b",
                                         wanted.found, rsp_ch.found));
            if (rsp_ch.bucket_full !== wanted.bucket_full)
               report_mismatch($sformatf("bucket_full expected %0b got %0b",
                                         wanted.bucket_full, rsp_ch.bucket_full));
            if (rsp_ch.evicted_fingerprint !== wanted.evicted_fingerprint)
               report_mismatch($sformatf("evicted_fingerprint expected %03h got %03h",
                                         wanted.evicted_fingerprint,
                                         rsp_ch.evicted_fingerprint));
         end
      end
   end

   initial begin
      error_count       = 0;
      cycle_count       = 0;
      sender_idle_pct   = 38;
      receiver_idle_pct = 78;
      foreach (bucket_image[i])
         bucket_image[i] = '0;

      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.operation       <= OP_LOOKUP;
      req_ch.fingerprint     <= '0;
      req_ch.primary_index   <= '0;
      req_ch.alternate_index <= '0;
      req_ch.victim_slot     <= '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The block holds ready low during its clearing pass; the handshake
      // wait in issue_request absorbs that.
      load_directed_plan();
      foreach (directed_plan[i])
         issue_request(directed_plan[i].stimulus, directed_plan[i].typed,
                       directed_plan[i].outcome);

      // Phase 1: slow sender, very slow receiver (already set).
      repeat (RANDOM_PER_PHASE) issue_request(random_request(), 1'b0, '0);
      // Phase 2: roles swapped.
      sender_idle_pct   = 78;
      receiver_idle_pct = 38;
      repeat (RANDOM_PER_PHASE) issue_request(random_request(), 1'b0, '0);
      // Phase 3: back to back, no stalls.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      repeat (RANDOM_PER_PHASE) issue_request(random_request(), 1'b0, '0);
      req_ch.valid <= 1'b0;

      // Drain; the run limit catches a block that stops responding.
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      if (error_count == 0) begin
         $display("cuckoo_filter_bucket_table test passed");
      end else begin
         $display("cuckoo_filter_bucket_table test failed");
      end
      $finish;
   end

endmodule
